### hw/rtl/bfcld_pkg.sv
// Package for the byte FIFO command deframer: word structs, status and action codes,
// and the packet length lookup. It depends on nothing else.
package bfcld_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned PROG_W    = 12;
  localparam int unsigned LEN_W     = 12;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_STORED     = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_DELIVERED  = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  // Packet code bytes
  localparam logic [7:0] CODE_FF = 8'hFF;
  localparam logic [7:0] CODE_AC = 8'hAC;
  localparam logic [7:0] CODE_P  = 8'h70;
  localparam logic [7:0] CODE_A5 = 8'hA5;
  localparam logic [7:0] CODE_A1 = 8'hA1;
  localparam logic [7:0] CODE_AE = 8'hAE;

  // Action the controller orders for the current word
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STORE = 3'd1,
    ACT_DROP  = 3'd2,
    ACT_TAKE  = 3'd3,
    ACT_FIRST = 3'd4,
    ACT_ABORT = 3'd5,
    ACT_WAIT  = 3'd6
  } act_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [7:0]          out_byte;
    logic                first_of_packet;
    logic                last_of_packet;
    logic [PROG_W-1:0]   progress;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    act_t act;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd;
    logic full;
    logic empty;
    logic releasing;
    logic fits;
  } dp_stat_t;

  // Payload length that follows a packet code byte
  function automatic logic [LEN_W-1:0] payload_len(input logic [7:0] code);
    logic [LEN_W-1:0] len;
    case (code)
      CODE_FF: len = LEN_W'(8);
      CODE_AC: len = LEN_W'(2);
      CODE_P:  len = LEN_W'(20);
      CODE_A5, CODE_A1: len = LEN_W'(2048);
      CODE_AE: len = LEN_W'(6);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/bfcld_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module bfcld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### hw/rtl/bfcld_ctrl.sv
// Controller for the byte FIFO command deframer: sequences each word and picks the action.
// Depends on bfcld_pkg.
module bfcld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bfcld_pkg::dp_stat_t stat,
  output bfcld_pkg::ctl_cmd_t cmd,
  output logic                busy,
  output logic                out_strobe
);
  import bfcld_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;
  act_t   act;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  // Pick the action from the held word and buffer status
  always_comb begin
    act = ACT_NONE;
    if (state_r == S_EXEC) begin
      if (stat.cmd == CMD_PUSH) begin
        act = stat.full ? ACT_DROP : ACT_STORE;
      end else if (stat.releasing) begin
        act = stat.empty ? ACT_ABORT : ACT_TAKE;
      end else if (stat.empty || !stat.fits) begin
        act = ACT_WAIT;
      end else begin
        act = ACT_FIRST;
      end
    end
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd.capture = start && !busy;
  assign cmd.act     = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EXEC);
    end
  end

endmodule

### hw/rtl/bfcld_dp.sv
// Datapath for the byte FIFO command deframer: pointers, release count, result registers.
// Depends on bfcld_pkg and bfcld_ram.
module bfcld_dp #(
  parameter int unsigned DEPTH = bfcld_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfcld_pkg::in_item_t  in_item,
  input  bfcld_pkg::ctl_cmd_t  cmd,
  output bfcld_pkg::dp_stat_t  stat,
  output bfcld_pkg::out_item_t out_item
);
  import bfcld_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic             cmd_r;
  logic [7:0]       byte_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt, rd_inc;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_inc;
  logic [LEN_W-1:0] rel_r, rel_nxt;
  logic [LEN_W-1:0] len;
  logic [PTR_W:0]   held_ext;
  logic [PTR_W-1:0] held;
  logic [7:0]       head;
  status_t          status_r, status_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             first_r, first_nxt, last_r, last_nxt;
  logic             we;

  // Wrap pointers at the buffer depth
  assign rd_inc = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;

  // Fill level from the pointers
  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      held_ext = {1'b0, wr_ptr_r} - {1'b0, rd_ptr_r};
    end else begin
      held_ext = {1'b0, wr_ptr_r} + (PTR_W + 1)'(DEPTH) - {1'b0, rd_ptr_r};
    end
  end
  assign held = held_ext[PTR_W-1:0];

  assign len = payload_len(head);

  assign stat.cmd       = cmd_r;
  assign stat.full      = (wr_inc == rd_ptr_r);
  assign stat.empty     = (held == '0);
  assign stat.releasing = (rel_r != '0);
  assign stat.fits      = (held > PTR_W'(len));

  assign we = (cmd.act == ACT_STORE);

  bfcld_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wr_ptr_r),
    .wdata   (byte_r),
    .raddr   (rd_ptr_r),
    .rdata_r (head)
  );

  // Carry out the ordered action
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    rel_nxt    = rel_r;
    status_nxt = status_r;
    obyte_nxt  = obyte_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    if (cmd.act != ACT_NONE) begin
      obyte_nxt = '0;
      first_nxt = 1'b0;
      last_nxt  = 1'b0;
    end
    case (cmd.act)
      ACT_STORE: begin
        wr_ptr_nxt = wr_inc;
        status_nxt = ST_STORED;
      end
      ACT_DROP: status_nxt = ST_DROPPED;
      ACT_TAKE: begin
        rd_ptr_nxt = rd_inc;
        rel_nxt    = rel_r - 1'b1;
        status_nxt = ST_DELIVERED;
        obyte_nxt  = head;
        last_nxt   = (rel_r == LEN_W'(1));
      end
      ACT_FIRST: begin
        rd_ptr_nxt = rd_inc;
        rel_nxt    = len;
        status_nxt = ST_DELIVERED;
        obyte_nxt  = head;
        first_nxt  = 1'b1;
        last_nxt   = (len == '0);
      end
      ACT_ABORT: begin
        rel_nxt    = '0;
        status_nxt = ST_INCOMPLETE;
      end
      ACT_WAIT: status_nxt = ST_INCOMPLETE;
      default: ;
    endcase
  end

  // Hold the accepted word and register the result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_item.cmd;
      byte_r <= in_item.byte_in;
    end
    status_r <= status_nxt;
    obyte_r  <= obyte_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      rel_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rel_r    <= rel_nxt;
    end
  end

  assign out_item.status          = status_r;
  assign out_item.out_byte        = obyte_r;
  assign out_item.first_of_packet = first_r;
  assign out_item.last_of_packet  = last_r;
  assign out_item.progress        = held[PROG_W-1:0];

endmodule

### hw/rtl/byte_fifo_command_length_deframer.sv
// Byte FIFO command deframer: receive ring buffer that releases whole command packets.
// Input word: start/busy handshake with in_item (cmd, byte_in); a word is taken at a
// rising edge with start high and busy low. cmd 0 pushes byte_in, cmd 1 pops.
// Result word: out_item on the cycle out_strobe is high, one result per input word;
// the receiver cannot stall, so each result is shown exactly once.
// A pop looks up the payload length of the code byte at the head and delivers that
// packet byte by byte once the whole packet is buffered, marking first and last.
// Timing: busy is high for one cycle after a word is taken (the buffer RAM has a
// registered read); out_strobe follows in the next cycle. A new word is taken only
// while busy is low, the result of one word showing while the next is accepted.
// The buffer holds at most DEPTH-1 bytes; progress gives the fill level, low 12 bits.
// Reset (synchronous, active low) empties the buffer and ends any release;
// buffer contents are not cleared.
module byte_fifo_command_length_deframer #(
  parameter int unsigned DEPTH = bfcld_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bfcld_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output bfcld_pkg::out_item_t out_item
);
  import bfcld_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  bfcld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (dp_stat),
    .cmd        (ctl_cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  bfcld_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (ctl_cmd),
    .stat     (dp_stat),
    .out_item (out_item)
  );

  // Accepted word occupies the block next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // Result follows each busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_strobe) else $error("missing result strobe");

  // First mark only on a delivered byte
  a_first_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.first_of_packet |-> out_item.status == ST_DELIVERED)
    else $error("first mark without delivery");

endmodule
